>>> src/gif_first_frame_filter_macros.svh
// ----------------------------------------------------------------------------
// GIF first-frame filter assertion macros
// Short forms for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GIF_FIRST_FRAME_FILTER_MACROS_SVH
`define GIF_FIRST_FRAME_FILTER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GFF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define GFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/gff_pkg.sv
// ----------------------------------------------------------------------------
// GIF first-frame filter package
// Shared byte codes, queue word type and colour table size helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gff_pkg;

  // Block introducers and labels.
  localparam logic [7:0] GFF_TRAILER   = 8'h3B;
  localparam logic [7:0] GFF_INTRO     = 8'h21;
  localparam logic [7:0] GFF_IMAGE     = 8'h2C;
  localparam logic [7:0] GFF_LBL_GCE   = 8'hF9;
  localparam logic [7:0] GFF_LBL_CMT   = 8'hFE;
  localparam logic [7:0] GFF_LBL_TEXT  = 8'h01;
  localparam logic [7:0] GFF_LBL_APP   = 8'hFF;

  // Signature bytes: "GIF87a" / "GIF89a".
  localparam logic [7:0] GFF_SIG_G     = 8'h47;
  localparam logic [7:0] GFF_SIG_I     = 8'h49;
  localparam logic [7:0] GFF_SIG_F     = 8'h46;
  localparam logic [7:0] GFF_SIG_8     = 8'h38;
  localparam logic [7:0] GFF_SIG_7     = 8'h37;
  localparam logic [7:0] GFF_SIG_9     = 8'h39;
  localparam logic [7:0] GFF_SIG_A     = 8'h61;

  // Default depth of the word queue between parser and output stage.
  localparam int GFF_QDEPTH_DEF = 4;

  // One queued word: a byte, optionally preceded by a held 0x21.
  typedef struct packed {
    logic       two;
    logic [7:0] data;
  } gff_word_t;

  // Push request from the parser.
  typedef struct packed {
    logic      valid;
    gff_word_t word;
  } gff_push_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } gff_qstat_t;

  // Colour table length in bytes from a packed field.
  function automatic logic [9:0] gff_table_size(input logic [7:0] packed_byte);
    logic [3:0] sh;
    sh = {1'b0, packed_byte[2:0]} + 4'd1;
    return packed_byte[7] ? (10'd3 << sh) : 10'd0;
  endfunction

endpackage

>>> src/gff_parser.sv
// ----------------------------------------------------------------------------
// GIF first-frame filter parser
// Front part: takes one stream byte per cycle unless stalled, tracks the block
// structure and decides which bytes are kept, pushing them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gff_parser
  import gff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_stream,
  output gff_push_t  push
);

  typedef enum logic [3:0] {
    PH_START, PH_LABEL, PH_HEADER, PH_GTABLE, PH_GCE, PH_FIXED,
    PH_IMGDESC, PH_LTABLE, PH_LZW, PH_SUBLEN, PH_SUBDATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  sub_r, sub_nxt;
  logic [9:0]  tb_r, tb_nxt;
  logic        fid_r, fid_nxt;
  logic        keep_r, keep_nxt;
  logic        pass_r, pass_nxt;
  logic        emit, two;
  logic        sig_ok;
  logic        tb_done;

  // The counted run ends on its last byte.
  assign tb_done = (tb_r <= 10'd1);

  // Signature check by position within the header.
  always_comb begin
    case (cnt_r)
      4'd1:    sig_ok = (data_byte == GFF_SIG_I);
      4'd2:    sig_ok = (data_byte == GFF_SIG_F);
      4'd3:    sig_ok = (data_byte == GFF_SIG_8);
      4'd4:    sig_ok = (data_byte == GFF_SIG_7) || (data_byte == GFF_SIG_9);
      4'd5:    sig_ok = (data_byte == GFF_SIG_A);
      default: sig_ok = 1'b1;
    endcase
  end

  // Block parsing and keep or drop decision for the current byte.
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sub_nxt   = sub_r;
    tb_nxt    = tb_r;
    fid_nxt   = fid_r;
    keep_nxt  = keep_r;
    pass_nxt  = pass_r;
    emit      = 1'b0;
    two       = 1'b0;
    if (pass_r) begin
      emit = 1'b1;
    end else begin
      case (phase_r)
        PH_START: begin
          keep_nxt = 1'b1;
          if (data_byte == GFF_TRAILER) begin
            emit = 1'b1;
          end else if (data_byte == GFF_INTRO) begin
            if (end_of_stream) begin
              emit = 1'b1;
            end else begin
              phase_nxt = PH_LABEL;
            end
          end else if (data_byte == GFF_IMAGE) begin
            keep_nxt = !fid_r;
            if (!fid_r) begin
              fid_nxt = 1'b1;
              emit    = 1'b1;
            end
            cnt_nxt   = 4'd1;
            phase_nxt = PH_IMGDESC;
          end else if (data_byte == GFF_SIG_G) begin
            emit      = 1'b1;
            cnt_nxt   = 4'd1;
            phase_nxt = PH_HEADER;
          end else begin
            pass_nxt = 1'b1;
            emit     = 1'b1;
          end
        end
        PH_LABEL: begin
          case (data_byte)
            GFF_LBL_GCE: begin
              keep_nxt  = !fid_r;
              tb_nxt    = 10'd6;
              phase_nxt = PH_GCE;
            end
            GFF_LBL_CMT: begin
              keep_nxt  = 1'b1;
              phase_nxt = PH_SUBLEN;
            end
            GFF_LBL_TEXT: begin
              keep_nxt  = 1'b1;
              tb_nxt    = 10'd13;
              phase_nxt = PH_FIXED;
            end
            GFF_LBL_APP: begin
              keep_nxt  = 1'b1;
              tb_nxt    = 10'd12;
              phase_nxt = PH_FIXED;
            end
            default: begin
              keep_nxt  = 1'b1;
              pass_nxt  = 1'b1;
              phase_nxt = PH_START;
            end
          endcase
          // The held introducer goes out with its label.
          emit = keep_nxt;
          two  = keep_nxt;
        end
        PH_HEADER: begin
          emit = 1'b1;
          if (!sig_ok) begin
            pass_nxt  = 1'b1;
            phase_nxt = PH_START;
          end else begin
            if (cnt_r == 4'd10) begin
              tb_nxt = gff_table_size(data_byte);
            end
            if (cnt_r >= 4'd12) begin
              phase_nxt = (tb_nxt != 10'd0) ? PH_GTABLE : PH_START;
            end else begin
              cnt_nxt = cnt_r + 4'd1;
            end
          end
        end
        PH_GTABLE: begin
          emit = 1'b1;
          if (tb_done) begin
            tb_nxt    = 10'd0;
            phase_nxt = PH_START;
          end else begin
            tb_nxt = tb_r - 10'd1;
          end
        end
        PH_GCE: begin
          emit = keep_r;
          if (tb_done) begin
            tb_nxt    = 10'd0;
            phase_nxt = PH_START;
          end else begin
            tb_nxt = tb_r - 10'd1;
          end
        end
        PH_FIXED: begin
          emit = keep_r;
          if (tb_done) begin
            tb_nxt    = 10'd0;
            phase_nxt = PH_SUBLEN;
          end else begin
            tb_nxt = tb_r - 10'd1;
          end
        end
        PH_IMGDESC: begin
          emit = keep_r;
          if (cnt_r >= 4'd9) begin
            tb_nxt    = gff_table_size(data_byte);
            phase_nxt = (tb_nxt != 10'd0) ? PH_LTABLE : PH_LZW;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
        PH_LTABLE: begin
          emit = keep_r;
          if (tb_done) begin
            tb_nxt    = 10'd0;
            phase_nxt = PH_LZW;
          end else begin
            tb_nxt = tb_r - 10'd1;
          end
        end
        PH_LZW: begin
          emit      = keep_r;
          phase_nxt = PH_SUBLEN;
        end
        PH_SUBLEN: begin
          emit = keep_r;
          if (data_byte == 8'd0) begin
            phase_nxt = PH_START;
          end else begin
            sub_nxt   = data_byte;
            phase_nxt = PH_SUBDATA;
          end
        end
        PH_SUBDATA: begin
          emit = keep_r;
          if (sub_r <= 8'd1) begin
            sub_nxt   = 8'd0;
            phase_nxt = PH_SUBLEN;
          end else begin
            sub_nxt = sub_r - 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
    // The final byte of a stream leaves the parser ready for a new one.
    if (end_of_stream) begin
      phase_nxt = PH_START;
      cnt_nxt   = 4'd0;
      sub_nxt   = 8'd0;
      tb_nxt    = 10'd0;
      keep_nxt  = 1'b1;
      pass_nxt  = 1'b0;
    end
  end

  // Parser state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      cnt_r   <= 4'd0;
      sub_r   <= 8'd0;
      tb_r    <= 10'd0;
      fid_r   <= 1'b0;
      keep_r  <= 1'b1;
      pass_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      tb_r    <= tb_nxt;
      fid_r   <= fid_nxt;
      keep_r  <= keep_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign push.valid     = accept && emit;
  assign push.word.two  = two;
  assign push.word.data = data_byte;

endmodule

>>> src/gff_queue.sv
// ----------------------------------------------------------------------------
// GIF first-frame filter queue
// Short first-in first-out store of kept words between parser and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gff_queue
  import gff_pkg::*;
#(
  parameter int QDEPTH = GFF_QDEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gff_push_t                   push,
  input  logic                        pop,
  output gff_word_t                   rd_word,
  output gff_qstat_t                  stat,
  output logic [$clog2(QDEPTH+1)-1:0] level
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  gff_word_t         mem [QDEPTH];
  gff_word_t         head_r;
  logic [PW-1:0]     wr_r, wr_nxt;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push = push.valid && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push.word;
    end
  end

  // Head word register; a word written into the slot that becomes the head
  // goes straight through.
  always_ff @(posedge clk) begin
    if (do_push && (wr_r == rd_nxt)) begin
      head_r <= push.word;
    end else begin
      head_r <= mem[rd_nxt];
    end
  end

  assign rd_word    = head_r;
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CW'(QDEPTH));
  assign level      = cnt_r;

endmodule

>>> src/gff_emit.sv
// ----------------------------------------------------------------------------
// GIF first-frame filter output stage
// Back part: takes words from the queue and presents them as output bytes,
// sending a held 0x21 ahead of its label where the word asks for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gff_emit
  import gff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  gff_word_t  q_word,
  input  gff_qstat_t q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  gff_word_t word_r, word_nxt;
  logic      valid_r, valid_nxt;
  logic      intro_r, intro_nxt;

  // Load a new word when the register is empty or its last byte leaves.
  assign pop = !q_stat.empty && (!valid_r || (out_ready && !intro_r));

  always_comb begin
    valid_nxt = valid_r;
    intro_nxt = intro_r;
    word_nxt  = word_r;
    if (valid_r && out_ready) begin
      if (intro_r) begin
        intro_nxt = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
    if (pop) begin
      valid_nxt = 1'b1;
      intro_nxt = q_word.two;
      word_nxt  = q_word;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      intro_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      intro_r <= intro_nxt;
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid       = valid_r;
  assign out_byte        = intro_r ? GFF_INTRO : word_r.data;
  assign out_last_of_run = !intro_r;

endmodule

>>> src/gif_first_frame_filter.sv
// ----------------------------------------------------------------------------
// GIF first-frame filter
// Strips animation from a GIF stream, keeping the header, tables, non-graphic
// extensions, the trailer and the first graphic control block and image.
//
//   Channel | Handshake             | Word
//   --------+-----------------------+------------------------------------
//   input   | in_valid / in_ready   | in_data_byte, in_end_of_stream
//   output  | out_valid / out_ready | out_byte, out_last_of_run
//
// The parser accepts one byte per cycle while the queue has room.
// A kept byte goes through the queue into the output word register.
// An extension label that is kept goes out as two bytes: 0x21, then the label.
// in_ready depends only on the queue fill, never on out_ready directly.
// Reset is synchronous and active low; the queue and output stage start empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "gif_first_frame_filter_macros.svh"

module gif_first_frame_filter
  import gff_pkg::*;
#(
  parameter int QDEPTH = GFF_QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  gff_push_t                   push;
  gff_word_t                   q_word;
  gff_qstat_t                  q_stat;
  logic                        pop;
  logic                        accept;
  logic [$clog2(QDEPTH+1)-1:0] q_level;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  // Front: parsing and keep decision.
  gff_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .data_byte     (in_data_byte),
    .end_of_stream (in_end_of_stream),
    .push          (push)
  );

  // Queue between front and back.
  gff_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (pop),
    .rd_word (q_word),
    .stat    (q_stat),
    .level   (q_level)
  );

  // Back: output word register.
  gff_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_word          (q_word),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  // Checks on queue fill and on the introducer pairing.
  `GFF_ASSERT_ALWAYS(a_level_bound, q_level <= QDEPTH, "queue fill beyond depth")
  `GFF_ASSERT_IMPL(a_ready_full, !in_ready, q_level == QDEPTH, "stall without a full queue")
  `GFF_ASSERT_IMPL(a_intro_byte, out_valid && !out_last_of_run, out_byte == GFF_INTRO, "non-final word is not 0x21")
  `GFF_ASSERT_NEXT(a_label_next, out_valid && out_ready && !out_last_of_run, out_valid && out_last_of_run, "label does not follow 0x21")

endmodule

>>> tb/tb_gif_first_frame_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF first-frame filter testbench
// Feeds GIF byte streams into the filter and checks every output word against
// a behavioural model of the parser kept in this file. A short table of
// directed words comes first: header extremes, a comment, the trailer, a lone
// introducer, a bad signature and unknown blocks. Random streams follow. Most
// are well formed with random content and some are truncated, carry a broken
// signature or end in noise. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------

module tb_gif_first_frame_filter;
  import gff_pkg::*;

  // Parser phases of the behavioural model.
  typedef enum logic [3:0] {
    ST_BLOCK, ST_LABEL, ST_SIG, ST_GTAB, ST_GCE, ST_FIXED,
    ST_DESC, ST_LTAB, ST_LZW, ST_SUBLEN, ST_SUBDATA
  } parse_st_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
  } in_word_t;

  // One directed word, with its outputs typed in where they are obvious.
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    logic [1:0] n;
    logic [7:0] x0;
    logic [7:0] x1;
  } dir_row_t;

  // Block layout lengths.
  localparam logic [9:0] GCE_TAIL   = 10'd6;
  localparam logic [9:0] TEXT_FIXED = 10'd13;
  localparam logic [9:0] APP_FIXED  = 10'd12;
  localparam int         HDR_PACKED = 10;
  localparam int         HDR_LAST   = 12;
  localparam int         DESC_LAST  = 9;

  // Run shape.
  localparam int N_DIR       = 26;
  localparam int N_ITEMS     = 1700;
  localparam int CALM_AT     = 1450;
  localparam int MID_PAUSE   = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_end_of_stream;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  // Typed expectation travelling with the word on offer.
  logic       drv_typed;
  logic [1:0] drv_n;
  logic [7:0] drv_x0;
  logic [7:0] drv_x1;

  out_word_t kept_q[$];
  in_word_t  stim_q[$];
  int        errors;
  int        sent;
  bit        calm;
  bit        hold_rx;
  int        tx_gap_pct;

  // Model state.
  parse_st_t  st;
  logic [9:0] pos;
  logic [7:0] sub_left;
  logic [9:0] tab_left;
  logic       img_seen;
  logic       keep;
  logic       held;
  logic       thru;

  gif_first_frame_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Colour table length from a packed field: bit 7 present, 3 << (n + 1) bytes.
  function automatic logic [9:0] colour_tab_len(input logic [7:0] p);
    return p[7] ? (10'd6 << p[2:0]) : 10'd0;
  endfunction

  // Counts down a table or fixed run; true on its last byte.
  function automatic bit tab_run_done();
    if (tab_left <= 10'd1) begin
      tab_left = '0;
      return 1'b1;
    end
    tab_left = tab_left - 10'd1;
    return 1'b0;
  endfunction

  task automatic clear_parser();
    st       = ST_BLOCK;
    pos      = '0;
    sub_left = '0;
    tab_left = '0;
    keep     = 1'b1;
    held     = 1'b0;
    thru     = 1'b0;
  endtask

  // Works out the filtered bytes that one input byte releases.
  task automatic filter_byte(input logic [7:0] b, input logic eos, output int n,
                             output logic [7:0] r0, output logic [7:0] r1);
    logic [7:0] rb [2];
    bit         ok;
    n     = 0;
    rb[0] = '0;
    rb[1] = '0;
    if (thru) begin
      rb[0] = b;
      n     = 1;
    end else begin
      case (st)
        ST_BLOCK: begin
          keep = 1'b1;
          if (b == GFF_TRAILER) begin
            rb[0] = b;
            n     = 1;
          end else if (b == GFF_INTRO) begin
            // A lone introducer at the end of the stream is released at once.
            if (eos) begin
              rb[0] = b;
              n     = 1;
            end else begin
              held = 1'b1;
              st   = ST_LABEL;
            end
          end else if (b == GFF_IMAGE) begin
            keep = !img_seen;
            if (keep) begin
              img_seen = 1'b1;
              rb[0]    = b;
              n        = 1;
            end
            pos = 10'd1;
            st  = ST_DESC;
          end else if (b == GFF_SIG_G) begin
            rb[0] = b;
            n     = 1;
            pos   = 10'd1;
            st    = ST_SIG;
          end else begin
            thru  = 1'b1;
            rb[0] = b;
            n     = 1;
          end
        end
        ST_LABEL: begin
          held = 1'b0;
          keep = 1'b1;
          if (b == GFF_LBL_GCE) begin
            keep     = !img_seen;
            tab_left = GCE_TAIL;
            st       = ST_GCE;
          end else if (b == GFF_LBL_CMT) begin
            st = ST_SUBLEN;
          end else if (b == GFF_LBL_TEXT) begin
            tab_left = TEXT_FIXED;
            st       = ST_FIXED;
          end else if (b == GFF_LBL_APP) begin
            tab_left = APP_FIXED;
            st       = ST_FIXED;
          end else begin
            thru = 1'b1;
            st   = ST_BLOCK;
          end
          if (keep) begin
            rb[0] = GFF_INTRO;
            rb[1] = b;
            n     = 2;
          end
        end
        ST_SIG: begin
          rb[0] = b;
          n     = 1;
          case (pos)
            10'd1:   ok = (b == GFF_SIG_I);
            10'd2:   ok = (b == GFF_SIG_F);
            10'd3:   ok = (b == GFF_SIG_8);
            10'd4:   ok = (b == GFF_SIG_7) || (b == GFF_SIG_9);
            10'd5:   ok = (b == GFF_SIG_A);
            default: ok = 1'b1;
          endcase
          if (!ok) begin
            thru = 1'b1;
            st   = ST_BLOCK;
          end else begin
            if (pos == HDR_PACKED) tab_left = colour_tab_len(b);
            if (pos >= HDR_LAST) st = (tab_left != 0) ? ST_GTAB : ST_BLOCK;
            else pos = pos + 10'd1;
          end
        end
        ST_GTAB: begin
          rb[0] = b;
          n     = 1;
          if (tab_run_done()) st = ST_BLOCK;
        end
        ST_GCE: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (tab_run_done()) st = ST_BLOCK;
        end
        ST_FIXED: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (tab_run_done()) st = ST_SUBLEN;
        end
        ST_DESC: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (pos >= DESC_LAST) begin
            tab_left = colour_tab_len(b);
            st       = (tab_left != 0) ? ST_LTAB : ST_LZW;
          end else begin
            pos = pos + 10'd1;
          end
        end
        ST_LTAB: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (tab_run_done()) st = ST_LZW;
        end
        ST_LZW: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          st = ST_SUBLEN;
        end
        ST_SUBLEN: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (b == 8'h00) begin
            st = ST_BLOCK;
          end else begin
            sub_left = b;
            st       = ST_SUBDATA;
          end
        end
        default: begin
          if (keep) begin
            rb[0] = b;
            n     = 1;
          end
          if (sub_left <= 8'd1) begin
            sub_left = '0;
            st       = ST_SUBLEN;
          end else begin
            sub_left = sub_left - 8'd1;
          end
        end
      endcase
    end
    // The end of a stream returns the parser to block start; the image flag stays.
    if (eos) clear_parser();
    r0 = rb[0];
    r1 = rb[1];
  endtask

  // Checks output words and records the expectations of accepted input words.
  always @(posedge clk) begin : watch
    int         n;
    logic [7:0] r0;
    logic [7:0] r1;
    out_word_t  w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          $error("unexpected word: out_byte %02h, out_last_of_run %0b",
                 out_byte, out_last_of_run);
          errors++;
        end else begin
          w = kept_q.pop_front();
          if (out_byte !== w.b) begin
            $error("out_byte: expected %02h, got %02h", w.b, out_byte);
            errors++;
          end
          if (out_last_of_run !== w.last) begin
            $error("out_last_of_run: expected %0b, got %0b", w.last, out_last_of_run);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        filter_byte(in_data_byte, in_end_of_stream, n, r0, r1);
        if (drv_typed) begin
          n  = drv_n;
          r0 = drv_x0;
          r1 = drv_x1;
        end
        if (n >= 1) begin
          w.b    = r0;
          w.last = (n == 1);
          kept_q.push_back(w);
        end
        if (n == 2) begin
          w.b    = r1;
          w.last = 1'b1;
          kept_q.push_back(w);
        end
      end
    end
  end

  // Offers one word, after an occasional idle burst, and waits for its acceptance.
  task automatic offer(input logic [7:0] b, input logic e, input logic typed,
                       input logic [1:0] n, input logic [7:0] x0, input logic [7:0] x1);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= e;
    drv_typed        <= typed;
    drv_n            <= n;
    drv_x0           <= x0;
    drv_x1           <= x1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  // Stops offering until every expected word has come out.
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic dir_row_t mk(input logic [7:0] b, input logic e, input logic typed,
                                  input logic [1:0] n, input logic [7:0] x0,
                                  input logic [7:0] x1);
    dir_row_t r;
    r.b     = b;
    r.eos   = e;
    r.typed = typed;
    r.n     = n;
    r.x0    = x0;
    r.x1    = x1;
    return r;
  endfunction

  task automatic push_b(input logic [7:0] b);
    in_word_t w;
    w.b   = b;
    w.eos = 1'b0;
    stim_q.push_back(w);
  endtask

  // Packed field with a small table size, now and then the largest.
  function automatic logic [7:0] rand_packed(input int deep_odds);
    logic [7:0] p;
    p      = 8'($urandom);
    p[2:0] = ($urandom_range(0, deep_odds) == 0) ? 3'd7 : 3'($urandom_range(0, 2));
    return p;
  endfunction

  task automatic put_subs();
    int cnt;
    int len;
    cnt = $urandom_range(0, 3);
    repeat (cnt) begin
      len = ($urandom_range(0, 40) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
      push_b(8'(len));
      repeat (len) push_b(8'($urandom));
    end
    push_b(8'h00);
  endtask

  task automatic put_header(input bit break_sig);
    logic [7:0] sig [6];
    logic [7:0] p;
    int         k;
    sig[0] = GFF_SIG_G;
    sig[1] = GFF_SIG_I;
    sig[2] = GFF_SIG_F;
    sig[3] = GFF_SIG_8;
    sig[4] = $urandom_range(0, 1) ? GFF_SIG_9 : GFF_SIG_7;
    sig[5] = GFF_SIG_A;
    // A broken signature differs in exactly one of the bytes after the G.
    if (break_sig) begin
      k = $urandom_range(1, 5);
      if (k == 4) sig[4] = GFF_SIG_A;
      else sig[k] = sig[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < 6; k++) push_b(sig[k]);
    repeat (4) push_b(8'($urandom));
    p = rand_packed(25);
    push_b(p);
    repeat (2) push_b(8'($urandom));
    repeat (colour_tab_len(p)) push_b(8'($urandom));
  endtask

  task automatic put_gce();
    push_b(GFF_INTRO);
    push_b(GFF_LBL_GCE);
    repeat (GCE_TAIL) push_b(8'($urandom));
  endtask

  task automatic put_image();
    logic [7:0] p;
    push_b(GFF_IMAGE);
    repeat (DESC_LAST - 1) push_b(8'($urandom));
    p = rand_packed(40);
    if ($urandom_range(0, 2) != 0) p[7] = 1'b0;
    push_b(p);
    repeat (colour_tab_len(p)) push_b(8'($urandom));
    push_b(8'($urandom));
    put_subs();
  endtask

  task automatic put_ext();
    push_b(GFF_INTRO);
    case ($urandom_range(0, 2))
      0: begin
        push_b(GFF_LBL_CMT);
      end
      1: begin
        push_b(GFF_LBL_TEXT);
        repeat (TEXT_FIXED) push_b(8'($urandom));
      end
      default: begin
        push_b(GFF_LBL_APP);
        repeat (APP_FIXED) push_b(8'($urandom));
      end
    endcase
    put_subs();
  endtask

  // Builds one stream: mostly well formed, some truncated, broken or noisy.
  task automatic build_stream();
    int         kind;
    int         cut;
    logic [7:0] x;
    stim_q.delete();
    kind = $urandom_range(0, 9);
    put_header(kind == 8);
    repeat ($urandom_range(1, 3)) begin
      repeat ($urandom_range(0, 2)) put_ext();
      if ($urandom_range(0, 9) < 7) put_gce();
      put_image();
    end
    if (kind == 9) begin
      case ($urandom_range(0, 2))
        0: begin
          do x = 8'($urandom);
          while (x == GFF_TRAILER || x == GFF_INTRO || x == GFF_IMAGE || x == GFF_SIG_G);
          push_b(x);
        end
        1: begin
          push_b(GFF_INTRO);
          do x = 8'($urandom);
          while (x == GFF_LBL_GCE || x == GFF_LBL_CMT || x == GFF_LBL_TEXT ||
                 x == GFF_LBL_APP);
          push_b(x);
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 6)) push_b(8'($urandom));
      if ($urandom_range(0, 1) != 0) push_b(GFF_INTRO);
    end else begin
      push_b(GFF_TRAILER);
    end
    if (kind == 7) begin
      cut = $urandom_range(1, stim_q.size());
      while (stim_q.size() > cut) void'(stim_q.pop_back());
    end
    stim_q[stim_q.size() - 1].eos = 1'b1;
  endtask

  // Receiver: random stalls, one long hold-off, and none near the end.
  initial begin : receiver
    int stall_pct;
    int left;
    out_ready = 1'b0;
    stall_pct = 20;
    left      = 0;
    @(negedge clk);
    forever begin
      if (left == 0) begin
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
        left      = 200;
      end
      left--;
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Sender: reset, directed table, random streams, then the final check.
  initial begin : stimulus
    dir_row_t rows [N_DIR];
    int       i;
    int       guard;
    bit       paused_mid;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_end_of_stream = 1'b0;
    drv_typed        = 1'b0;
    drv_n            = '0;
    drv_x0           = '0;
    drv_x1           = '0;
    errors           = 0;
    sent             = 0;
    calm             = 1'b0;
    hold_rx          = 1'b0;
    paused_mid       = 1'b0;
    tx_gap_pct       = 20;
    clear_parser();
    img_seen = 1'b0;

    rows = '{
      // Header with extreme screen sizes and no global table.
      mk(GFF_SIG_G, 1'b0, 1'b1, 2'd1, GFF_SIG_G, 8'h00),
      mk(GFF_SIG_I, 1'b0, 1'b1, 2'd1, GFF_SIG_I, 8'h00),
      mk(GFF_SIG_F, 1'b0, 1'b1, 2'd1, GFF_SIG_F, 8'h00),
      mk(GFF_SIG_8, 1'b0, 1'b1, 2'd1, GFF_SIG_8, 8'h00),
      mk(GFF_SIG_9, 1'b0, 1'b1, 2'd1, GFF_SIG_9, 8'h00),
      mk(GFF_SIG_A, 1'b0, 1'b1, 2'd1, GFF_SIG_A, 8'h00),
      mk(8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00),
      mk(8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00),
      mk(8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00),
      mk(8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00),
      mk(8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00),
      mk(8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00),
      mk(8'hFF, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00),
      // Empty comment: the introducer is held until its label.
      mk(GFF_INTRO, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00),
      mk(GFF_LBL_CMT, 1'b0, 1'b1, 2'd2, GFF_INTRO, GFF_LBL_CMT),
      mk(8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00),
      // Trailer closing the stream, then a lone introducer at end of stream.
      mk(GFF_TRAILER, 1'b1, 1'b1, 2'd1, GFF_TRAILER, 8'h00),
      mk(GFF_INTRO, 1'b1, 1'b1, 2'd1, GFF_INTRO, 8'h00),
      // Bad signature switches to pass-through.
      mk(GFF_SIG_G, 1'b0, 1'b1, 2'd1, GFF_SIG_G, 8'h00),
      mk(8'h58, 1'b0, 1'b1, 2'd1, 8'h58, 8'h00),
      mk(GFF_INTRO, 1'b0, 1'b1, 2'd1, GFF_INTRO, 8'h00),
      mk(8'h00, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00),
      // Unknown label releases the held introducer with it.
      mk(GFF_INTRO, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00),
      mk(8'h77, 1'b0, 1'b1, 2'd2, GFF_INTRO, 8'h77),
      mk(8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00),
      // Unknown block start.
      mk(8'h00, 1'b1, 1'b1, 2'd1, 8'h00, 8'h00)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIR; i++) begin
      offer(rows[i].b, rows[i].eos, rows[i].typed, rows[i].n, rows[i].x0, rows[i].x1);
    end
    drain_pause();

    // The receiver holds off while the first random stream fills the block.
    hold_rx = 1'b1;
    while (sent < N_DIR + N_ITEMS) begin
      build_stream();
      tx_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      foreach (stim_q[j]) begin
        if (sent >= N_DIR + CALM_AT) calm = 1'b1;
        offer(stim_q[j].b, stim_q[j].eos, 1'b0, 2'd0, 8'h00, 8'h00);
      end
      if (!paused_mid && sent >= N_DIR + MID_PAUSE) begin
        drain_pause();
        paused_mid = 1'b1;
      end
    end

    // Let the last words drain, then allow a few more cycles for strays.
    calm = 1'b1;
    in_valid <= 1'b0;
    guard = 0;
    while (kept_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (kept_q.size() != 0) begin
      $error("%0d expected words never arrived", kept_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_gif_first_frame_filter: clean");
    end else begin
      $display("tb_gif_first_frame_filter: errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("tb_gif_first_frame_filter: errors");
    $finish;
  end

endmodule

>>> gif_first_frame_filter.f
+incdir+src
src/gff_pkg.sv
src/gff_parser.sv
src/gff_queue.sv
src/gff_emit.sv
src/gif_first_frame_filter.sv
tb/tb_gif_first_frame_filter.sv
